// ===== rtl/vmtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel mask topology counter package
// Shared widths, register indexes and count, scan and write-back types for the counter blocks.
// ----------------------------------------------------------------------------
package vmtc_pkg;

    localparam int MAX_X = 256;
    localparam int MAX_Y = 256;
    localparam int MAX_Z = 256;

    localparam int POS_X_W = $clog2(MAX_X);
    localparam int POS_Y_W = $clog2(MAX_Y);
    localparam int POS_Z_W = $clog2(MAX_Z);
    localparam int ADDR_W  = POS_X_W + POS_Y_W;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 25;
    localparam int NUM_CNT   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam int CNT_VOXEL   = 0;
    localparam int CNT_X_EDGE  = 1;
    localparam int CNT_Y_EDGE  = 2;
    localparam int CNT_Z_EDGE  = 3;
    localparam int CNT_XY_FACE = 4;
    localparam int CNT_XZ_FACE = 5;
    localparam int CNT_YZ_FACE = 6;
    localparam int CNT_CUBE    = 7;

    typedef logic [CNT_W-1:0] t_count;
    typedef t_count [NUM_CNT-1:0] t_totals;

    // Position of the voxel whose request is being taken.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [POS_X_W-1:0] x;
        logic               x_nz;
        logic               y_nz;
        logic               z_nz;
        logic               last;
    } t_scan;

    // Write-back of one processed voxel into the plane and line stores.
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [POS_X_W-1:0] x;
        logic               v;
        logic               p0;
    } t_wb;

endpackage

// ===== rtl/voxel_mask_topology_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel mask topology counter
// Counts set voxels, edges, faces and cubes of a raster-ordered voxel mask
// using a plane store and a row store, and emits eight totals per volume.
// ----------------------------------------------------------------------------
// Throughput: one voxel request per cycle except while the last voxel waits;
// the store read and write-back pipeline is two stages deep and forwards on a
// same-entry collision. Totals are registered once the last voxel is counted.
// The last voxel of a volume waits only while the previous totals are unclaimed.
// Reset: sizes return to 256 on each axis, position and counters clear; the
// store contents are never used before they are written in a volume.
module voxel_mask_topology_counter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vmtc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vmtc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_voxel_positive,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [vmtc_pkg::CNT_W-1:0]     o_voxel_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_x_edge_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_y_edge_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_z_edge_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_xy_face_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_xz_face_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_yz_face_total,
    output logic [vmtc_pkg::CNT_W-1:0]     o_cube_total
);

    logic              w_accept;
    logic              w_restart;
    logic              w_stall;
    logic              w_mem_p0;
    logic [1:0]        w_line;
    vmtc_pkg::t_scan   w_scan;
    vmtc_pkg::t_wb     w_wb;
    vmtc_pkg::t_totals w_totals;

    assign o_ready  = ~w_stall;
    assign w_accept = i_valid & ~w_stall;

    vmtc_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .o_restart  (w_restart),
        .o_scan     (w_scan)
    );

    // Plane store: each entry holds the latest voxel at that x, y, which is
    // the previous plane's voxel until the current plane overwrites it.
    vmtc_ram #(
        .DEPTH_W (vmtc_pkg::ADDR_W),
        .DATA_W  (1)
    ) u_plane (
        .i_clk   (i_clk),
        .i_we    (w_wb.we),
        .i_waddr (w_wb.addr),
        .i_wdata (w_wb.v),
        .i_re    (w_accept),
        .i_raddr (w_scan.addr),
        .o_rdata (w_mem_p0)
    );

    // Row store: the voxel one row back in this plane and in the previous one.
    vmtc_ram #(
        .DEPTH_W (vmtc_pkg::POS_X_W),
        .DATA_W  (2)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_wb.we),
        .i_waddr (w_wb.x),
        .i_wdata ({w_wb.v, w_wb.p0}),
        .i_re    (w_accept),
        .i_raddr (w_scan.x),
        .o_rdata (w_line)
    );

    vmtc_count u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_accept  (w_accept),
        .i_voxel   (i_voxel_positive),
        .i_scan    (w_scan),
        .i_mem_p0  (w_mem_p0),
        .i_line    (w_line),
        .o_stall   (w_stall),
        .o_wb      (w_wb),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_totals  (w_totals)
    );

    assign o_voxel_total   = w_totals[vmtc_pkg::CNT_VOXEL];
    assign o_x_edge_total  = w_totals[vmtc_pkg::CNT_X_EDGE];
    assign o_y_edge_total  = w_totals[vmtc_pkg::CNT_Y_EDGE];
    assign o_z_edge_total  = w_totals[vmtc_pkg::CNT_Z_EDGE];
    assign o_xy_face_total = w_totals[vmtc_pkg::CNT_XY_FACE];
    assign o_xz_face_total = w_totals[vmtc_pkg::CNT_XZ_FACE];
    assign o_yz_face_total = w_totals[vmtc_pkg::CNT_YZ_FACE];
    assign o_cube_total    = w_totals[vmtc_pkg::CNT_CUBE];

endmodule

// ===== rtl/vmtc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel mask topology counter RAM
// Simple dual-port RAM, registered read, write data forwarded on a collision.
// ----------------------------------------------------------------------------
module vmtc_ram #(
    parameter int DEPTH_W = 8,
    parameter int DATA_W  = 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [DEPTH_W-1:0] i_waddr,
    input  logic [DATA_W-1:0]  i_wdata,
    input  logic               i_re,
    input  logic [DEPTH_W-1:0] i_raddr,
    output logic [DATA_W-1:0]  o_rdata
);

    logic [DATA_W-1:0] r_mem [1 << DEPTH_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vmtc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel mask topology counter scan
// Size registers and the raster position and plane address of the next voxel.
// ----------------------------------------------------------------------------
module vmtc_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vmtc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vmtc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    output logic                          o_restart,
    output vmtc_pkg::t_scan               o_scan
);

    logic [vmtc_pkg::POS_X_W-1:0] r_sx_m1;
    logic [vmtc_pkg::POS_Y_W-1:0] r_sy_m1;
    logic [vmtc_pkg::POS_Z_W-1:0] r_sz_m1;
    logic [vmtc_pkg::POS_X_W-1:0] r_x;
    logic [vmtc_pkg::POS_Y_W-1:0] r_y;
    logic [vmtc_pkg::POS_Z_W-1:0] r_z;
    logic [vmtc_pkg::ADDR_W-1:0]  r_addr;
    logic                         w_last_x;
    logic                         w_last_y;
    logic                         w_last_z;
    logic                         w_restart;

    // Returns the size minus one, with zero taken as one and the limit applied.
    function automatic logic [11:0] size_m1(input logic [vmtc_pkg::CFG_W-1:0] w,
                                            input int lim);
        logic [11:0] r;
        if (w == '0) begin
            r = '0;
        end else if (32'(w) > lim) begin
            r = 12'(lim - 1);
        end else begin
            r = 12'(w) - 12'd1;
        end
        return r;
    endfunction

    assign w_restart = i_cfg_we && ((i_cfg_idx == vmtc_pkg::CFG_SIZE_X) ||
                                    (i_cfg_idx == vmtc_pkg::CFG_SIZE_Y) ||
                                    (i_cfg_idx == vmtc_pkg::CFG_SIZE_Z));

    assign w_last_x = (r_x == r_sx_m1);
    assign w_last_y = (r_y == r_sy_m1);
    assign w_last_z = (r_z == r_sz_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx_m1 <= vmtc_pkg::POS_X_W'(vmtc_pkg::MAX_X - 1);
            r_sy_m1 <= vmtc_pkg::POS_Y_W'(vmtc_pkg::MAX_Y - 1);
            r_sz_m1 <= vmtc_pkg::POS_Z_W'(vmtc_pkg::MAX_Z - 1);
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_addr  <= '0;
        end else if (w_restart) begin
            case (i_cfg_idx)
                vmtc_pkg::CFG_SIZE_X: begin
                    r_sx_m1 <= vmtc_pkg::POS_X_W'(size_m1(i_cfg_data, vmtc_pkg::MAX_X));
                end
                vmtc_pkg::CFG_SIZE_Y: begin
                    r_sy_m1 <= vmtc_pkg::POS_Y_W'(size_m1(i_cfg_data, vmtc_pkg::MAX_Y));
                end
                vmtc_pkg::CFG_SIZE_Z: begin
                    r_sz_m1 <= vmtc_pkg::POS_Z_W'(size_m1(i_cfg_data, vmtc_pkg::MAX_Z));
                end
                default: begin
                end
            endcase
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_addr <= '0;
        end else if (i_accept) begin
            if (!w_last_x) begin
                r_x    <= r_x + 1'b1;
                r_addr <= r_addr + 1'b1;
            end else begin
                r_x <= '0;
                if (!w_last_y) begin
                    r_y    <= r_y + 1'b1;
                    r_addr <= r_addr + 1'b1;
                end else begin
                    r_y    <= '0;
                    r_addr <= '0;
                    if (w_last_z) begin
                        r_z <= '0;
                    end else begin
                        r_z <= r_z + 1'b1;
                    end
                end
            end
        end
    end

    assign o_restart   = w_restart;
    assign o_scan.addr = r_addr;
    assign o_scan.x    = r_x;
    assign o_scan.x_nz = (r_x != '0);
    assign o_scan.y_nz = (r_y != '0);
    assign o_scan.z_nz = (r_z != '0);
    assign o_scan.last = w_last_x && w_last_y && w_last_z;

endmodule

// ===== rtl/vmtc_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel mask topology counter pattern stage
// Matches each voxel against its neighbours, bumps the counters and holds
// the volume totals until they are taken.
// ----------------------------------------------------------------------------
module vmtc_count (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_accept,
    input  logic              i_voxel,
    input  vmtc_pkg::t_scan   i_scan,
    input  logic              i_mem_p0,
    input  logic [1:0]        i_line,
    output logic              o_stall,
    output vmtc_pkg::t_wb     o_wb,
    output logic              o_valid,
    input  logic              i_ready,
    output vmtc_pkg::t_totals o_totals
);

    logic                         r_s1_valid;
    logic                         r_s1_v;
    vmtc_pkg::t_scan              r_s1_scan;
    logic                         r_hv;
    logic                         r_hp0;
    logic                         r_hcym;
    logic                         r_hpym;
    vmtc_pkg::t_totals            r_cnt;
    vmtc_pkg::t_totals            r_out;
    logic                         r_out_valid;
    vmtc_pkg::t_totals            w_sum;
    logic [vmtc_pkg::NUM_CNT-1:0] w_inc;
    logic                         w_adv;
    logic                         w_p0;
    logic                         w_cym;
    logic                         w_pym;
    logic                         w_cxm;
    logic                         w_pxm;
    logic                         w_cxym;
    logic                         w_pxym;

    // Neighbours at x-1 come from the previous voxel, which is in the same
    // row whenever x is non-zero.
    assign w_p0   = r_s1_scan.z_nz & i_mem_p0;
    assign w_cym  = r_s1_scan.y_nz & i_line[1];
    assign w_pym  = r_s1_scan.y_nz & i_line[0];
    assign w_cxm  = r_s1_scan.x_nz & r_hv;
    assign w_pxm  = r_s1_scan.x_nz & r_hp0;
    assign w_cxym = r_s1_scan.x_nz & r_hcym;
    assign w_pxym = r_s1_scan.x_nz & r_hpym;

    always_comb begin
        w_inc = '0;
        w_inc[vmtc_pkg::CNT_VOXEL]   = r_s1_v;
        w_inc[vmtc_pkg::CNT_X_EDGE]  = r_s1_v & w_cxm;
        w_inc[vmtc_pkg::CNT_Y_EDGE]  = r_s1_v & w_cym;
        w_inc[vmtc_pkg::CNT_Z_EDGE]  = r_s1_v & w_p0;
        w_inc[vmtc_pkg::CNT_XY_FACE] = r_s1_v & w_cxm & w_cym & w_cxym;
        w_inc[vmtc_pkg::CNT_XZ_FACE] = r_s1_v & w_cxm & w_p0 & w_pxm;
        w_inc[vmtc_pkg::CNT_YZ_FACE] = r_s1_v & w_cym & w_p0 & w_pym;
        w_inc[vmtc_pkg::CNT_CUBE]    = r_s1_v & w_cxm & w_cym & w_cxym &
                                       w_p0 & w_pxm & w_pym & w_pxym;
        for (int k = 0; k < vmtc_pkg::NUM_CNT; k++) begin
            w_sum[k] = r_cnt[k] + vmtc_pkg::CNT_W'(w_inc[k]);
        end
    end

    // The last voxel of a volume waits while the previous totals are unclaimed.
    assign o_stall = r_s1_valid & r_s1_scan.last & r_out_valid & ~i_ready;
    assign w_adv   = r_s1_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_adv && r_s1_scan.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_restart || (w_adv && r_s1_scan.last)) begin
                r_cnt <= '0;
            end else if (w_adv) begin
                r_cnt <= w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_v    <= i_voxel;
            r_s1_scan <= i_scan;
        end
        if (w_adv) begin
            r_hv   <= r_s1_v;
            r_hp0  <= w_p0;
            r_hcym <= w_cym;
            r_hpym <= w_pym;
        end
        if (w_adv && r_s1_scan.last) begin
            r_out <= w_sum;
        end
    end

    assign o_wb.we   = w_adv;
    assign o_wb.addr = r_s1_scan.addr;
    assign o_wb.x    = r_s1_scan.x;
    assign o_wb.v    = r_s1_v;
    assign o_wb.p0   = w_p0;

    assign o_valid  = r_out_valid;
    assign o_totals = r_out;

endmodule

// ===== test/voxel_mask_topology_counter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel mask topology counter testbench
// Streams voxel flags through the counter under random idling on both sides
// and checks every set of volume totals against a predictor or a short table, which
// covers single voxels, a full 2x2x2 cube, restarts and the reserved register.
// A full-length row and a held-off output follow, then random volumes.
// ----------------------------------------------------------------------------
module voxel_mask_topology_counter_unit_tb;

    import vmtc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;
    localparam int PLANE_CELLS   = MAX_X * MAX_Y;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 60;
    localparam int DIRECTED_ROWS = 30;
    localparam int ITEM_TARGET   = 600;

    typedef enum logic [1:0] {ROW_WRITE, ROW_VOXEL, ROW_TOTALS} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_W-1:0]      cfg_data;
        logic                  voxel;
        t_totals               totals;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = '0;
    logic [CFG_W-1:0]     i_cfg_data       = '0;
    logic                 i_valid          = 1'b0;
    logic                 i_voxel_positive = 1'b0;
    logic                 i_ready          = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    t_count               o_voxel_total;
    t_count               o_x_edge_total;
    t_count               o_y_edge_total;
    t_count               o_z_edge_total;
    t_count               o_xy_face_total;
    t_count               o_xz_face_total;
    t_count               o_yz_face_total;
    t_count               o_cube_total;

    voxel_mask_topology_counter_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_voxel_positive (i_voxel_positive),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_voxel_total    (o_voxel_total),
        .o_x_edge_total   (o_x_edge_total),
        .o_y_edge_total   (o_y_edge_total),
        .o_z_edge_total   (o_z_edge_total),
        .o_xy_face_total  (o_xy_face_total),
        .o_xz_face_total  (o_xz_face_total),
        .o_yz_face_total  (o_yz_face_total),
        .o_cube_total     (o_cube_total)
    );

    // Totals are written as {cube, yz, xz, xy, z edge, y edge, x edge, voxels}.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_WRITE,  CFG_RESERVED, 9'h1ff, 1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_X,   9'd0,   1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_Y,   9'd0,   1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_Z,   9'd0,   1'b0, '0},
        '{ROW_TOTALS, '0, '0, 1'b1,
          {25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd1}},
        '{ROW_TOTALS, '0, '0, 1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_X,   9'd2,   1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_Y,   9'd2,   1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_Z,   9'd2,   1'b0, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_TOTALS, '0, '0, 1'b1,
          {25'd1, 25'd2, 25'd2, 25'd2, 25'd4, 25'd4, 25'd4, 25'd8}},
        '{ROW_WRITE,  CFG_SIZE_X,   9'd3,   1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_Y,   9'd1,   1'b0, '0},
        '{ROW_WRITE,  CFG_SIZE_Z,   9'd1,   1'b0, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        // The reserved index must leave the row in progress untouched.
        '{ROW_WRITE,  CFG_RESERVED, 9'h000, 1'b0, '0},
        '{ROW_TOTALS, '0, '0, 1'b1,
          {25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd2, 25'd3}},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_VOXEL,  '0, '0, 1'b0, '0},
        // Rewriting a size drops the partial row.
        '{ROW_WRITE,  CFG_SIZE_Y,   9'd1,   1'b0, '0},
        '{ROW_VOXEL,  '0, '0, 1'b0, '0},
        '{ROW_VOXEL,  '0, '0, 1'b1, '0},
        '{ROW_TOTALS, '0, '0, 1'b1,
          {25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd1, 25'd2}}
    };

    string field_names [NUM_CNT] = '{"voxel_total", "x_edge_total", "y_edge_total",
                                     "z_edge_total", "xy_face_total", "xz_face_total",
                                     "yz_face_total", "cube_total"};
    int unsigned densities [5] = '{10, 50, 80, 95, 100};

    // Predictor state.
    bit          plane_below [PLANE_CELLS];
    bit          plane_now   [PLANE_CELLS];
    int unsigned span_x = MAX_X;
    int unsigned span_y = MAX_Y;
    int unsigned span_z = MAX_Z;
    int unsigned scan_x = 0;
    int unsigned scan_y = 0;
    int unsigned scan_z = 0;
    t_totals     tally  = '0;

    t_totals     pending_totals [$];
    int unsigned voxels_sent     = 0;
    int unsigned volumes_sent    = 0;
    int unsigned volumes_checked = 0;
    int unsigned size_writes     = 0;
    int unsigned mismatches      = 0;
    bit          steady          = 1'b0;
    bit          hold_request    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("voxel_mask_topology_counter_unit verification failed");
        $finish;
    end

    function automatic int unsigned clamp_span(logic [CFG_W-1:0] value, int unsigned hi);
        if (value == 0) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic void apply_size_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_W-1:0] data);
        case (idx)
            CFG_SIZE_X: span_x = clamp_span(data, MAX_X);
            CFG_SIZE_Y: span_y = clamp_span(data, MAX_Y);
            CFG_SIZE_Z: span_z = clamp_span(data, MAX_Z);
            default:    return;
        endcase
        scan_x = 0;
        scan_y = 0;
        scan_z = 0;
        tally  = '0;
    endfunction

    // Adds one voxel to the running counts; returns 1 with the totals when
    // the voxel closes the volume.
    function automatic bit tally_voxel(input logic v, output t_totals totals);
        int unsigned here;
        int unsigned i;
        bit          cxm, cym, cxym, p0, pxm, pym, pxym;
        bit          done;
        here   = scan_y * span_x + scan_x;
        totals = '0;
        done   = 1'b0;
        cxm  = (scan_x > 0) && plane_now[here - 1];
        cym  = (scan_y > 0) && plane_now[here - span_x];
        cxym = (scan_x > 0) && (scan_y > 0) && plane_now[here - span_x - 1];
        p0   = (scan_z > 0) && plane_below[here];
        pxm  = (scan_z > 0) && (scan_x > 0) && plane_below[here - 1];
        pym  = (scan_z > 0) && (scan_y > 0) && plane_below[here - span_x];
        pxym = (scan_z > 0) && (scan_x > 0) && (scan_y > 0)
               && plane_below[here - span_x - 1];

        tally[CNT_VOXEL]   = tally[CNT_VOXEL]   + v;
        tally[CNT_X_EDGE]  = tally[CNT_X_EDGE]  + (v & cxm);
        tally[CNT_Y_EDGE]  = tally[CNT_Y_EDGE]  + (v & cym);
        tally[CNT_Z_EDGE]  = tally[CNT_Z_EDGE]  + (v & p0);
        tally[CNT_XY_FACE] = tally[CNT_XY_FACE] + (v & cxm & cym & cxym);
        tally[CNT_XZ_FACE] = tally[CNT_XZ_FACE] + (v & cxm & p0 & pxm);
        tally[CNT_YZ_FACE] = tally[CNT_YZ_FACE] + (v & cym & p0 & pym);
        tally[CNT_CUBE]    = tally[CNT_CUBE]
                             + (v & cxm & cym & cxym & p0 & pxm & pym & pxym);
        plane_now[here] = v;

        if (scan_x + 1 < span_x) begin
            scan_x++;
        end else begin
            scan_x = 0;
            if (scan_y + 1 < span_y) begin
                scan_y++;
            end else begin
                scan_y = 0;
                for (i = 0; i < span_x * span_y; i++) plane_below[i] = plane_now[i];
                if (scan_z + 1 < span_z) begin
                    scan_z++;
                end else begin
                    scan_z = 0;
                    totals = tally;
                    tally  = '0;
                    done   = 1'b1;
                end
            end
        end
        return done;
    endfunction

    function automatic logic [CFG_W-1:0] random_span();
        if ($urandom_range(0, 7) == 0) return '0;
        return CFG_W'($urandom_range(1, 5));
    endfunction

    // Writes happen only with the block drained, so no totals are in flight.
    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_size_write(idx, data);
        size_writes++;
    endtask

    task automatic send_voxel(input logic v, input bit typed, input t_totals typed_totals);
        int unsigned gap;
        t_totals     predicted;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_voxel_positive <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        voxels_sent++;
        if (tally_voxel(v, predicted)) begin
            pending_totals.push_back(typed ? typed_totals : predicted);
            volumes_sent++;
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                             input logic [CFG_W-1:0] sz, input bit [2:0] write_mask,
                             input bit reserved, input int unsigned volumes,
                             input int unsigned tail, input int unsigned density);
        int unsigned count;
        int unsigned n;
        if (write_mask[0]) write_size(CFG_SIZE_X, sx);
        if (write_mask[1]) write_size(CFG_SIZE_Y, sy);
        if (write_mask[2]) write_size(CFG_SIZE_Z, sz);
        if (reserved) write_size(CFG_RESERVED, CFG_W'($urandom_range(0, 511)));
        count = volumes * span_x * span_y * span_z + tail;
        for (n = 0; n < count; n++) send_voxel($urandom_range(0, 99) < density, 1'b0, '0);
    endtask

    initial begin : request_source
        int row;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            case (directed_rows[row].kind)
                ROW_WRITE:  write_size(directed_rows[row].cfg_idx, directed_rows[row].cfg_data);
                ROW_VOXEL:  send_voxel(directed_rows[row].voxel, 1'b0, '0);
                ROW_TOTALS: send_voxel(directed_rows[row].voxel, 1'b1, directed_rows[row].totals);
                default: ;
            endcase
        end

        // A full-length row; the oversized write is taken as the maximum.
        run_phase(9'd511, 9'd1, 9'd1, 3'b111, 1'b0, 1, 3, 90);

        // Single-voxel volumes against a stalled output fill the pipeline.
        steady = 1'b1;
        run_phase(9'd1, 9'd1, 9'd1, 3'b111, 1'b0, 0, 0, 100);
        hold_request = 1'b1;
        run_phase(9'd1, 9'd1, 9'd1, 3'b000, 1'b0, 30, 0, 70);

        while (voxels_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            run_phase(random_span(), random_span(), random_span(),
                      3'($urandom_range(0, 7)), $urandom_range(0, 5) == 0,
                      $urandom_range(1, 3),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
                      densities[$urandom_range(0, 4)]);
        end

        i_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d voxel requests, %0d volume totals checked, %0d size writes.",
                 voxels_sent, volumes_checked, size_writes);
        $display("Volumes ranged from one voxel to a 256-voxel row, with the output held off.");
        if (mismatches == 0) begin
            $display("voxel_mask_topology_counter_unit verification clean");
        end else begin
            $display("voxel_mask_topology_counter_unit verification failed");
        end
        $finish;
    end

    function automatic void check_totals();
        t_totals seen;
        t_totals want;
        int      k;
        seen[CNT_VOXEL]   = o_voxel_total;
        seen[CNT_X_EDGE]  = o_x_edge_total;
        seen[CNT_Y_EDGE]  = o_y_edge_total;
        seen[CNT_Z_EDGE]  = o_z_edge_total;
        seen[CNT_XY_FACE] = o_xy_face_total;
        seen[CNT_XZ_FACE] = o_xz_face_total;
        seen[CNT_YZ_FACE] = o_yz_face_total;
        seen[CNT_CUBE]    = o_cube_total;
        if (pending_totals.size() == 0) begin
            mismatches++;
            $display("%0t: totals delivered with no volume pending, voxel_total %0d",
                     $time, seen[CNT_VOXEL]);
            return;
        end
        want = pending_totals.pop_front();
        volumes_checked++;
        for (k = 0; k < NUM_CNT; k++) begin
            if (seen[k] !== want[k]) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, field_names[k],
                         want[k], seen[k]);
            end
        end
    endfunction

    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            check_totals();
        end
    end

endmodule
